// File: rtl/core/ascr_pkg.sv
// ----------------------------------------------------------------------------
// ascr_pkg: shared definitions for the adaptive stream count regulator
// Widths, register indexes, reset values, state codes and the fixed-point
// exponential averaging function.
// ----------------------------------------------------------------------------
package ascr_pkg;

   localparam int TIME_WIDTH    = 20;
   localparam int FRACTION_BITS = 16;
   localparam int COUNT_WIDTH   = 8;

   // A Q0.FRACTION_BITS fraction needs one extra bit to hold exactly 1.0.
   localparam int FRAC_WIDTH  = FRACTION_BITS + 1;
   localparam int BLEND_WIDTH = (TIME_WIDTH > FRAC_WIDTH) ? TIME_WIDTH : FRAC_WIDTH;
   localparam int SUM_WIDTH   = BLEND_WIDTH + FRAC_WIDTH + 1;

   localparam logic [FRAC_WIDTH-1:0] FRAC_ONE = FRAC_WIDTH'(1) << FRACTION_BITS;
   localparam logic [FRAC_WIDTH-1:0] FRAC_HALF = FRAC_WIDTH'(1) << (FRACTION_BITS - 1);

   // Request payload: cpu_time, gpu_time, gpu_util, padded to whole bytes.
   localparam int REQ_FIELD_BITS = 2 * TIME_WIDTH + FRAC_WIDTH;
   localparam int REQ_DATA_WIDTH = ((REQ_FIELD_BITS + 7) / 8) * 8;
   // Response payload: stream_count, count_changed, inject_compute,
   // bottleneck_class, utilization_level, padded to whole bytes.
   localparam int RSP_FIELD_BITS = COUNT_WIDTH + 1 + 1 + 2 + 2;
   localparam int RSP_DATA_WIDTH = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam int CSR_DATA_WIDTH_A = (TIME_WIDTH > FRAC_WIDTH) ? TIME_WIDTH : FRAC_WIDTH;
   localparam int CSR_DATA_WIDTH   =
      (CSR_DATA_WIDTH_A > COUNT_WIDTH) ? CSR_DATA_WIDTH_A : COUNT_WIDTH;

   typedef enum logic [2:0] {
      CSR_SMOOTHING_ALPHA    = 3'd0,
      CSR_HYSTERESIS_LOW     = 3'd1,
      CSR_HYSTERESIS_HIGH    = 3'd2,
      CSR_MIN_STREAMS        = 3'd3,
      CSR_MAX_STREAMS        = 3'd4,
      CSR_ADAPTIVE_ENABLE    = 3'd5,
      CSR_CPU_BOUND_MARGIN   = 3'd6,
      CSR_UTIL_LOW_THRESHOLD = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      BN_BALANCED      = 2'd0,
      BN_CPU_BOUND     = 2'd1,
      BN_GPU_UNDERUSED = 2'd2
   } bottleneck_type;

   typedef enum logic [1:0] {
      LEVEL_LOW    = 2'd0,
      LEVEL_MEDIUM = 2'd1,
      LEVEL_HIGH   = 2'd2
   } level_type;

   // Register reset values (0.1, 0.6, 0.9 in Q0.16 and a 2 ms margin).
   localparam logic [FRAC_WIDTH-1:0]  RST_SMOOTHING_ALPHA    = FRAC_WIDTH'(6554);
   localparam logic [FRAC_WIDTH-1:0]  RST_HYSTERESIS_LOW     = FRAC_WIDTH'(39322);
   localparam logic [FRAC_WIDTH-1:0]  RST_HYSTERESIS_HIGH    = FRAC_WIDTH'(58982);
   localparam logic [COUNT_WIDTH-1:0] RST_MIN_STREAMS        = COUNT_WIDTH'(2);
   localparam logic [COUNT_WIDTH-1:0] RST_MAX_STREAMS        = COUNT_WIDTH'(8);
   localparam logic [TIME_WIDTH-1:0]  RST_CPU_BOUND_MARGIN   = TIME_WIDTH'(2000);
   localparam logic [FRAC_WIDTH-1:0]  RST_UTIL_LOW_THRESHOLD = FRAC_WIDTH'(39322);
   localparam logic [COUNT_WIDTH-1:0] RST_CURRENT_STREAMS    = COUNT_WIDTH'(4);

   // avg' = (a*x + (1-a)*avg + 1/2) >> FRACTION_BITS, rounding half up.
   // The result never exceeds the larger of x and avg.
   function automatic logic [BLEND_WIDTH-1:0] blend(
      input logic [FRAC_WIDTH-1:0]  weight,
      input logic [BLEND_WIDTH-1:0] sample,
      input logic [BLEND_WIDTH-1:0] average
   );
      logic [FRAC_WIDTH-1:0] keep;
      logic [SUM_WIDTH-1:0]  sum;
      keep = FRAC_ONE - weight;
      sum  = SUM_WIDTH'(weight) * SUM_WIDTH'(sample)
           + SUM_WIDTH'(keep) * SUM_WIDTH'(average)
           + SUM_WIDTH'(FRAC_HALF);
      return sum[FRACTION_BITS +: BLEND_WIDTH];
   endfunction

endpackage

// File: rtl/core/adaptive_stream_count_regulator.sv
// ----------------------------------------------------------------------------
// adaptive_stream_count_regulator: frame-sample driven stream count control
// Averages CPU time, GPU time and GPU utilization, classifies the bottleneck,
// tracks a utilization level with hysteresis and steps the stream count.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the req_ channel carries one frame sample. Every request
//   produces exactly one response on the rsp_ channel with the stream count
//   after that frame, a changed flag, the inject flag, the bottleneck class
//   and the utilization level.
//   The request is first captured in an input register. While it is held
//   there, the averages, classification, level and count are computed in one
//   combinational pass and written to the state and the response register
//   once the response register is free or being emptied.
//   A new request can be accepted every cycle while the receiver keeps up; the
//   throughput is one request per cycle, set by the averaging state update.
//   When the receiver stalls, the response register holds its result and the
//   input register still takes one more request; after that req_tready drops
//   until the response is taken. Nothing is lost or repeated.
//   The csr_ channel writes the eight registers by index and is always ready;
//   the user must write it only while no request is in flight; the block does
//   not enforce this. A write to either stream limit pulls the count into the
//   new limits at once. Reset (synchronous, active high) restores the register
//   defaults, clears the averages, sets the level to medium and the count to
//   four, and empties both the input and the response register.
// ----------------------------------------------------------------------------
module adaptive_stream_count_regulator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0 up: cpu_time, gpu_time, gpu_util, zero padding.
   input  logic [ascr_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // Fields from bit 0 up: stream_count, count_changed, inject_compute,
   // bottleneck_class, utilization_level, zero padding.
   output logic [ascr_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  ascr_pkg::csr_index_type               csr_index,
   input  logic [ascr_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import ascr_pkg::*;

   // Configuration registers.
   logic [FRAC_WIDTH-1:0]  alpha_ff;
   logic [FRAC_WIDTH-1:0]  hyst_low_ff;
   logic [FRAC_WIDTH-1:0]  hyst_high_ff;
   logic [COUNT_WIDTH-1:0] min_streams_ff;
   logic [COUNT_WIDTH-1:0] max_streams_ff;
   logic                   enable_ff;
   logic [TIME_WIDTH-1:0]  margin_ff;
   logic [FRAC_WIDTH-1:0]  util_thresh_ff;

   // Regulator state. The bottleneck class is not needed from one frame to
   // the next, so it lives only in the response register.
   logic [TIME_WIDTH-1:0]  avg_cpu_ff,   avg_cpu_in;
   logic [TIME_WIDTH-1:0]  avg_gpu_ff,   avg_gpu_in;
   logic [FRAC_WIDTH-1:0]  avg_util_ff,  avg_util_in;
   level_type              level_ff,     level_in;
   bottleneck_type         bneck_in;
   logic [COUNT_WIDTH-1:0] streams_ff,   streams_in;
   logic                   inject_ff,    inject_in;

   // Input register.
   logic                   in_valid_ff;
   logic [TIME_WIDTH-1:0]  in_cpu_ff;
   logic [TIME_WIDTH-1:0]  in_gpu_ff;
   logic [FRAC_WIDTH-1:0]  in_util_ff;

   // Response register.
   logic                   out_valid_ff;
   logic [RSP_DATA_WIDTH-1:0] out_data_ff, out_data_in;

   logic advance;
   logic req_fire;
   logic csr_fire;

   // Working values for the single update pass.
   logic [FRAC_WIDTH-1:0]  weight;
   logic [FRAC_WIDTH-1:0]  util_sat;
   logic [COUNT_WIDTH-1:0] eff_min, eff_max;
   logic [COUNT_WIDTH-1:0] step_down, step_up;
   logic [TIME_WIDTH:0]    gpu_plus_margin;
   logic [COUNT_WIDTH-1:0] new_min, new_max;
   logic [COUNT_WIDTH-1:0] clamp_min, clamp_max, clamped;

   // The stage advances when the response register is free or being emptied.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // Effective limits: the minimum is at least one, the maximum at least the minimum.
   assign eff_min = (min_streams_ff == '0) ? COUNT_WIDTH'(1) : min_streams_ff;
   assign eff_max = (max_streams_ff < eff_min) ? eff_min : max_streams_ff;

   assign step_down = (streams_ff > eff_min) ? streams_ff - COUNT_WIDTH'(1) : eff_min;
   assign step_up   = (streams_ff < eff_max) ? streams_ff + COUNT_WIDTH'(1) : eff_max;

   // Averaging of the sample held in the input register.
   always_comb begin
      weight   = (alpha_ff > FRAC_ONE) ? FRAC_ONE : alpha_ff;
      util_sat = (in_util_ff > FRAC_ONE) ? FRAC_ONE : in_util_ff;
      if (avg_cpu_ff == '0 && avg_gpu_ff == '0) begin
         // First sample after reset (or after the averages decayed to zero).
         avg_cpu_in  = in_cpu_ff;
         avg_gpu_in  = in_gpu_ff;
         avg_util_in = util_sat;
      end else begin
         avg_cpu_in  = TIME_WIDTH'(blend(weight, BLEND_WIDTH'(in_cpu_ff),
                                         BLEND_WIDTH'(avg_cpu_ff)));
         avg_gpu_in  = TIME_WIDTH'(blend(weight, BLEND_WIDTH'(in_gpu_ff),
                                         BLEND_WIDTH'(avg_gpu_ff)));
         avg_util_in = FRAC_WIDTH'(blend(weight, BLEND_WIDTH'(util_sat),
                                         BLEND_WIDTH'(avg_util_ff)));
      end
   end

   // Classification, hysteresis level, count step and inject flag.
   always_comb begin
      gpu_plus_margin = {1'b0, avg_gpu_in} + {1'b0, margin_ff};
      bneck_in  = BN_BALANCED;
      level_in  = level_ff;
      streams_in = streams_ff;
      inject_in = inject_ff;

      if (enable_ff) begin
         if ({1'b0, avg_cpu_in} > gpu_plus_margin) begin
            bneck_in = BN_CPU_BOUND;
         end else if (avg_util_in < util_thresh_ff) begin
            bneck_in = BN_GPU_UNDERUSED;
         end else begin
            bneck_in = BN_BALANCED;
         end

         unique case (level_ff)
            LEVEL_LOW: begin
               if (avg_util_in >= hyst_low_ff) level_in = LEVEL_MEDIUM;
            end
            LEVEL_MEDIUM: begin
               if (avg_util_in < hyst_low_ff) begin
                  level_in = LEVEL_LOW;
               end else if (avg_util_in > hyst_high_ff) begin
                  level_in = LEVEL_HIGH;
               end
            end
            default: begin
               // High, and any unused code, falls back to medium at the boundary.
               if (avg_util_in <= hyst_high_ff) level_in = LEVEL_MEDIUM;
            end
         endcase

         case (bneck_in)
            BN_CPU_BOUND: begin
               streams_in = step_down;
               inject_in  = 1'b0;
            end
            BN_GPU_UNDERUSED: begin
               streams_in = step_up;
               inject_in  = (level_in == LEVEL_LOW);
            end
            default: begin
               if (level_in == LEVEL_LOW) begin
                  streams_in = step_up;
               end else if (level_in == LEVEL_HIGH) begin
                  streams_in = step_down;
               end
               inject_in = 1'b0;
            end
         endcase
      end

      out_data_in = '0;
      out_data_in[COUNT_WIDTH-1:0]             = streams_in;
      out_data_in[COUNT_WIDTH]                 = (streams_in != streams_ff);
      out_data_in[COUNT_WIDTH+1]               = inject_in;
      out_data_in[COUNT_WIDTH+2 +: 2]          = bneck_in;
      out_data_in[COUNT_WIDTH+4 +: 2]          = level_in;
   end

   // A limit write clamps the current count into the new effective limits.
   always_comb begin
      new_min = (csr_index == CSR_MIN_STREAMS) ? csr_data[COUNT_WIDTH-1:0] : min_streams_ff;
      new_max = (csr_index == CSR_MAX_STREAMS) ? csr_data[COUNT_WIDTH-1:0] : max_streams_ff;
      clamp_min = (new_min == '0) ? COUNT_WIDTH'(1) : new_min;
      clamp_max = (new_max < clamp_min) ? clamp_min : new_max;
      clamped = streams_ff;
      if (clamped < clamp_min) clamped = clamp_min;
      if (clamped > clamp_max) clamped = clamp_max;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff       <= RST_SMOOTHING_ALPHA;
         hyst_low_ff    <= RST_HYSTERESIS_LOW;
         hyst_high_ff   <= RST_HYSTERESIS_HIGH;
         min_streams_ff <= RST_MIN_STREAMS;
         max_streams_ff <= RST_MAX_STREAMS;
         enable_ff      <= 1'b1;
         margin_ff      <= RST_CPU_BOUND_MARGIN;
         util_thresh_ff <= RST_UTIL_LOW_THRESHOLD;
      end else if (csr_fire) begin
         unique case (csr_index)
            CSR_SMOOTHING_ALPHA:    alpha_ff       <= csr_data[FRAC_WIDTH-1:0];
            CSR_HYSTERESIS_LOW:     hyst_low_ff    <= csr_data[FRAC_WIDTH-1:0];
            CSR_HYSTERESIS_HIGH:    hyst_high_ff   <= csr_data[FRAC_WIDTH-1:0];
            CSR_MIN_STREAMS:        min_streams_ff <= csr_data[COUNT_WIDTH-1:0];
            CSR_MAX_STREAMS:        max_streams_ff <= csr_data[COUNT_WIDTH-1:0];
            CSR_ADAPTIVE_ENABLE:    enable_ff      <= csr_data[0];
            CSR_CPU_BOUND_MARGIN:   margin_ff      <= csr_data[TIME_WIDTH-1:0];
            CSR_UTIL_LOW_THRESHOLD: util_thresh_ff <= csr_data[FRAC_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Regulator state and the handshake flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_cpu_ff   <= '0;
         avg_gpu_ff   <= '0;
         avg_util_ff  <= '0;
         level_ff     <= LEVEL_MEDIUM;
         streams_ff   <= RST_CURRENT_STREAMS;
         inject_ff    <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            avg_cpu_ff  <= avg_cpu_in;
            avg_gpu_ff  <= avg_gpu_in;
            avg_util_ff <= avg_util_in;
            level_ff    <= level_in;
            streams_ff  <= streams_in;
            inject_ff   <= inject_in;
         end else if (csr_fire &&
                      (csr_index == CSR_MIN_STREAMS || csr_index == CSR_MAX_STREAMS)) begin
            streams_ff <= clamped;
         end

         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cpu_ff  <= req_tdata[TIME_WIDTH-1:0];
         in_gpu_ff  <= req_tdata[TIME_WIDTH +: TIME_WIDTH];
         in_util_ff <= req_tdata[2*TIME_WIDTH +: FRAC_WIDTH];
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule
